@@ rtl/core/salc_pkg.sv @@
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types, widths and register codes of the set-associative LRU tag store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package salc_pkg;

    localparam int DEF_MAX_SETS  = 8192;
    localparam int DEF_WAYS      = 8;
    localparam int DEF_ADDR_BITS = 32;

    localparam int TAG_W     = 32;
    localparam int RANK_W    = 3;
    localparam int WAY_OUT_W = 3;

    localparam logic [RANK_W-1:0] RANK_TOP = 3'd7;

    localparam int BS_W       = 3;
    localparam int SS_W       = 4;
    localparam int AWAYS_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SHIFT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_SHIFT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_WAYS = 2'd2;

    localparam logic [BS_W-1:0]    RST_BLOCK_SHIFT = 3'd6;
    localparam logic [SS_W-1:0]    RST_SET_SHIFT   = 4'd5;
    localparam logic [AWAYS_W-1:0] RST_ACTIVE_WAYS = 4'd1;

    typedef struct packed {
        logic              valid;
        logic [TAG_W-1:0]  tag;
        logic [RANK_W-1:0] rank;
    } way_entry_t;

endpackage

@@ rtl/core/salc_in_if.sv @@
// ----------------------------------------------------------------------------
// salc_in_if
// Lookup channel: one byte address per transaction, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface salc_in_if
    import salc_pkg::*;
#(
    parameter int ADDR_BITS = DEF_ADDR_BITS
)
();
    logic                 valid;
    logic                 ready;
    logic [ADDR_BITS-1:0] address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

@@ rtl/core/salc_out_if.sv @@
// ----------------------------------------------------------------------------
// salc_out_if
// Result channel: hit flag and way used per transaction, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface salc_out_if
    import salc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [WAY_OUT_W-1:0] way_used;

    modport source (output valid, output hit, output way_used, input ready);
    modport sink   (input valid, input hit, input way_used, output ready);
endinterface

@@ rtl/core/salc_ram.sv @@
// ----------------------------------------------------------------------------
// salc_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module salc_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/set_assoc_lru_cache_lookup.sv @@
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_lookup
// Tag store of a set-associative cache with LRU replacement, one row per set.
// A lookup goes through compare and update before its result is registered;
// update waits while the result channel stalls. No new lookup is taken until
// the read-modify-write of a set row through the single tag RAM is done.
// Reset: a clearing pass zeroes each of the MAX_SETS rows (8192 by default);
// lookups are held off until it ends, configuration writes are taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module set_assoc_lru_cache_lookup
    import salc_pkg::*;
#(
    parameter int MAX_SETS  = DEF_MAX_SETS,
    parameter int WAYS      = DEF_WAYS,
    parameter int ADDR_BITS = DEF_ADDR_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    salc_in_if.sink               lookup,
    salc_out_if.source            result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SET_AW    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int SHIFT_MAX = $clog2(MAX_SETS + 1) - 1;
    localparam int WAY_AW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int NW_W      = $clog2(WAYS + 1);
    localparam int ENT_W     = $bits(way_entry_t);
    localparam int ROW_W     = WAYS * ENT_W;
    localparam int EXT_W     = (ADDR_BITS > TAG_W) ? ADDR_BITS : TAG_W;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_CMP,
        S_UPD
    } state_t;

    state_t               state_reg, state_next;
    logic [SET_AW-1:0]    clr_reg, clr_next;
    logic [TAG_W-1:0]     tag_reg, tag_next;
    logic [SET_AW-1:0]    set_reg, set_next;
    logic                 hit_reg, hit_next;
    logic [WAY_AW-1:0]    used_reg, used_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_hit_reg, out_hit_next;
    logic [WAY_OUT_W-1:0] out_way_reg, out_way_next;
    logic [BS_W-1:0]      bs_reg, bs_next;
    logic [SS_W-1:0]      ss_reg, ss_next;
    logic [AWAYS_W-1:0]   aw_reg, aw_next;

    logic [NW_W-1:0]      nways;
    logic [SS_W-1:0]      eff_shift;
    logic [SET_AW:0]      one_sh;
    logic [SET_AW:0]      mask_full;
    logic [EXT_W-1:0]     blk_ext;
    logic [TAG_W-1:0]     tag_in;
    logic [SET_AW-1:0]    set_in;
    logic                 accept;
    logic                 advance;

    logic [ROW_W-1:0]     rd_row;
    logic [ROW_W-1:0]     new_row;
    way_entry_t           ways_q [WAYS];

    logic                 hit_found;
    logic                 inv_found;
    logic [WAY_AW-1:0]    hit_idx;
    logic [WAY_AW-1:0]    inv_idx;
    logic [WAY_AW-1:0]    vic_idx;
    logic [RANK_W-1:0]    best;
    logic [RANK_W-1:0]    old_rank;

    logic                 ram_we;
    logic [SET_AW-1:0]    ram_waddr;
    logic [ROW_W-1:0]     ram_wdata;

    // Effective settings
    always_comb
    begin
        if (int'(aw_reg) > WAYS)
        begin
            nways = NW_W'(WAYS);
        end
        else if (aw_reg == '0)
        begin
            nways = NW_W'(1);
        end
        else
        begin
            nways = NW_W'(aw_reg);
        end

        if (int'(ss_reg) > SHIFT_MAX)
        begin
            eff_shift = SS_W'(SHIFT_MAX);
        end
        else
        begin
            eff_shift = ss_reg;
        end
    end

    assign one_sh    = (SET_AW + 1)'(1) << eff_shift;
    assign mask_full = one_sh - (SET_AW + 1)'(1);
    assign blk_ext   = EXT_W'(lookup.address) >> bs_reg;
    assign tag_in    = blk_ext[TAG_W-1:0];
    assign set_in    = blk_ext[SET_AW-1:0] & mask_full[SET_AW-1:0];

    assign lookup.ready = (state_reg == S_IDLE);
    assign accept       = lookup.valid && (state_reg == S_IDLE);
    assign advance      = !out_valid_reg || result.ready;

    assign result.valid    = out_valid_reg;
    assign result.hit      = out_hit_reg;
    assign result.way_used = out_way_reg;

    // Unpack the set row
    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            ways_q[i] = way_entry_t'(rd_row[i*ENT_W +: ENT_W]);
        end
    end

    // Hit, first invalid way and LRU victim
    always_comb
    begin
        hit_found = 1'b0;
        inv_found = 1'b0;
        hit_idx   = '0;
        inv_idx   = '0;
        vic_idx   = '0;
        best      = '0;
        for (int i = 0; i < WAYS; i++)
        begin
            if (i < int'(nways))
            begin
                if (!hit_found && ways_q[i].valid && (ways_q[i].tag == tag_reg))
                begin
                    hit_found = 1'b1;
                    hit_idx   = WAY_AW'(i);
                end
                if (!inv_found && !ways_q[i].valid)
                begin
                    inv_found = 1'b1;
                    inv_idx   = WAY_AW'(i);
                end
                if ((i == 0) || (ways_q[i].rank > best))
                begin
                    best    = ways_q[i].rank;
                    vic_idx = WAY_AW'(i);
                end
            end
        end
    end

    // Updated set row
    assign old_rank = ways_q[used_reg].rank;

    always_comb
    begin
        way_entry_t e;
        new_row = '0;
        for (int i = 0; i < WAYS; i++)
        begin
            e = ways_q[i];
            if (WAY_AW'(i) == used_reg)
            begin
                e.valid = 1'b1;
                e.tag   = tag_reg;
                e.rank  = '0;
            end
            else if ((i < int'(nways)) && e.valid && (!hit_reg || (e.rank < old_rank))
                     && (e.rank != RANK_TOP))
            begin
                e.rank = e.rank + RANK_W'(1);
            end
            new_row[i*ENT_W +: ENT_W] = e;
        end
    end

    // Next state
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        tag_next       = tag_reg;
        set_next       = set_reg;
        hit_next       = hit_reg;
        used_next      = used_reg;
        out_valid_next = out_valid_reg;
        out_hit_next   = out_hit_reg;
        out_way_next   = out_way_reg;
        bs_next        = bs_reg;
        ss_next        = ss_reg;
        aw_next        = aw_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_BLOCK_SHIFT: bs_next = cfg_data[BS_W-1:0];
                CFG_SET_SHIFT:   ss_next = cfg_data[SS_W-1:0];
                CFG_ACTIVE_WAYS: aw_next = cfg_data[AWAYS_W-1:0];
                default:         ;
            endcase
        end

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + SET_AW'(1);
                if (clr_reg == SET_AW'(MAX_SETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (lookup.valid)
                begin
                    tag_next   = tag_in;
                    set_next   = set_in;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                hit_next = hit_found;
                if (hit_found)
                begin
                    used_next = hit_idx;
                end
                else if (inv_found)
                begin
                    used_next = inv_idx;
                end
                else
                begin
                    used_next = vic_idx;
                end
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (advance)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = hit_reg;
                    out_way_next   = WAY_OUT_W'(used_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            tag_reg       <= '0;
            set_reg       <= '0;
            hit_reg       <= 1'b0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_hit_reg   <= 1'b0;
            out_way_reg   <= '0;
            bs_reg        <= RST_BLOCK_SHIFT;
            ss_reg        <= RST_SET_SHIFT;
            aw_reg        <= RST_ACTIVE_WAYS;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            tag_reg       <= tag_next;
            set_reg       <= set_next;
            hit_reg       <= hit_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
            out_hit_reg   <= out_hit_next;
            out_way_reg   <= out_way_next;
            bs_reg        <= bs_next;
            ss_reg        <= ss_next;
            aw_reg        <= aw_next;
        end
    end

    // Tag RAM port control
    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = (state_reg == S_UPD) && advance;
            ram_waddr = set_reg;
            ram_wdata = new_row;
        end
    end

    salc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SETS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (set_in),
        .rdata (rd_row)
    );

    a_accept_to_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_CMP))
        else $error("accepted transaction did not move to compare");

    a_result_from_upd: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_UPD))
        else $error("result raised outside update");

    a_hit_way_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_UPD) && hit_reg) |-> ways_q[used_reg].valid)
        else $error("hit on an invalid way");

    a_used_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD) |-> (used_reg < nways))
        else $error("way used beyond active ways");

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the set-associative LRU tag store. A scoreboard class
// keeps its own copy of valid bits, block tags and recency ranks, predicts the
// hit flag and way of every accepted lookup, and compares each result in order.
// Directed lookups cover field extremes, out-of-range settings, duplicate tags
// and eviction. Random phases at many settings mix reused blocks, same-set
// conflicts and random addresses under bursty input and a stalling output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import salc_pkg::*;

    localparam int SETS_LOG2    = $clog2(DEF_MAX_SETS);
    localparam int PIPE_LAT     = 3;
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 150;
    localparam int NUM_PHASES   = 12;

    typedef struct packed {
        logic                 hit;
        logic [WAY_OUT_W-1:0] way;
    } lookup_result_t;

    class lru_lookup_scoreboard;
        way_entry_t       tag_store [DEF_MAX_SETS*DEF_WAYS];
        lookup_result_t   expected_results [$];
        logic [BS_W-1:0]    blk_shift;
        logic [SS_W-1:0]    set_shift;
        logic [AWAYS_W-1:0] act_ways;
        int               errors;

        function new();
            foreach (tag_store[i])
            begin
                tag_store[i].valid = 1'b0;
                tag_store[i].tag   = '0;
                tag_store[i].rank  = '0;
            end
            blk_shift = RST_BLOCK_SHIFT;
            set_shift = RST_SET_SHIFT;
            act_ways  = RST_ACTIVE_WAYS;
            errors    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_BLOCK_SHIFT: blk_shift = data[BS_W-1:0];
                CFG_SET_SHIFT:   set_shift = data[SS_W-1:0];
                CFG_ACTIVE_WAYS: act_ways  = data[AWAYS_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        task report(string msg);
            if (errors < 100)
                $display("tb: mismatch: %s", msg);
            errors++;
        endtask

        function void predict_lookup(logic [DEF_ADDR_BITS-1:0] addr);
            logic [TAG_W-1:0] blk;
            int               sshift;
            int               nways;
            int               base;
            int               used;
            int               i;
            logic [RANK_W-1:0] old_rank;
            bit               hit;
            bit               found;
            lookup_result_t   res;
            blk = TAG_W'(addr >> blk_shift);
            sshift = set_shift;
            while (sshift > 0 && (64'd1 << sshift) > DEF_MAX_SETS)
                sshift--;
            nways = (act_ways == 0) ? 1 : ((act_ways > DEF_WAYS) ? DEF_WAYS : int'(act_ways));
            base = int'(blk & ((32'd1 << sshift) - 32'd1)) * DEF_WAYS;
            hit = 1'b0;
            found = 1'b0;
            used = 0;
            for (i = 0; i < nways; i++)
            begin
                if (!hit && tag_store[base+i].valid && tag_store[base+i].tag == blk)
                begin
                    used = i;
                    hit = 1'b1;
                end
            end
            if (!hit)
            begin
                for (i = 0; i < nways; i++)
                begin
                    if (!found && !tag_store[base+i].valid)
                    begin
                        used = i;
                        found = 1'b1;
                    end
                end
                if (!found)
                begin
                    used = 0;
                    for (i = 1; i < nways; i++)
                        if (tag_store[base+i].rank > tag_store[base+used].rank)
                            used = i;
                end
            end
            old_rank = tag_store[base+used].rank;
            for (i = 0; i < nways; i++)
            begin
                if (i != used && tag_store[base+i].valid &&
                    (!hit || tag_store[base+i].rank < old_rank))
                begin
                    if (tag_store[base+i].rank != RANK_TOP)
                        tag_store[base+i].rank++;
                end
            end
            tag_store[base+used].valid = 1'b1;
            tag_store[base+used].tag   = blk;
            tag_store[base+used].rank  = '0;
            res.hit = hit;
            res.way = used[WAY_OUT_W-1:0];
            expected_results.push_back(res);
        endfunction

        task check_result(logic hit, logic [WAY_OUT_W-1:0] way);
            lookup_result_t exp_res;
            if (expected_results.size() == 0)
            begin
                report($sformatf("result hit=%0b way=%0d with no pending lookup", hit, way));
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (hit !== exp_res.hit)
                    report($sformatf("hit %0b, expected %0b", hit, exp_res.hit));
                if (way !== exp_res.way)
                    report($sformatf("way_used %0d, expected %0d", way, exp_res.way));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    salc_in_if #(.ADDR_BITS(DEF_ADDR_BITS)) lookup_ch ();
    salc_out_if result_ch ();

    set_assoc_lru_cache_lookup dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .lookup    (lookup_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lru_lookup_scoreboard sb;
    bit hold_pending;

    logic [BS_W-1:0]          cur_bs;
    logic [SS_W-1:0]          cur_ss;
    logic [DEF_ADDR_BITS-1:0] recent_addr [16];
    int                       recent_n;
    int                       recent_wr;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb: FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && lookup_ch.valid === 1'b1 && lookup_ch.ready === 1'b1)
            sb.predict_lookup(lookup_ch.address);
        if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            sb.check_result(result_ch.hit, result_ch.way_used);
    end

    initial
    begin
        int mode;
        int n;
        int j;
        bit hold_done;
        hold_done = 1'b0;
        result_ch.ready = 1'b0;
        @(negedge clk);
        forever
        begin
            if (hold_pending && !hold_done)
            begin
                hold_done = 1'b1;
                for (j = 0; j < LONG_HOLD; j++)
                begin
                    @(negedge clk);
                    result_ch.ready <= 1'b0;
                end
            end
            mode = $urandom_range(0, 3);
            n = $urandom_range(4, 40);
            for (j = 0; j < n; j++)
            begin
                @(negedge clk);
                case (mode)
                    0:       result_ch.ready <= 1'b1;
                    1:       result_ch.ready <= 1'($urandom_range(0, 1));
                    2:       result_ch.ready <= (j % 4 == 3);
                    default: result_ch.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    task send_lookup(logic [DEF_ADDR_BITS-1:0] addr);
        @(negedge clk);
        lookup_ch.valid   <= 1'b1;
        lookup_ch.address <= addr;
        do
            @(posedge clk);
        while (lookup_ch.ready !== 1'b1);
    endtask

    task idle_cycles(int n);
        repeat (n)
        begin
            @(negedge clk);
            lookup_ch.valid <= 1'b0;
        end
    endtask

    task drain_results();
        idle_cycles(1);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 2) @(posedge clk);
    endtask

    task write_cfg(logic [CFG_DATA_W-1:0] bs, logic [SS_W-1:0] ss, logic [AWAYS_W-1:0] aw);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BLOCK_SHIFT;
        cfg_data  <= bs;
        sb.set_reg(CFG_BLOCK_SHIFT, bs);
        @(negedge clk);
        cfg_index <= CFG_SET_SHIFT;
        cfg_data  <= ss;
        sb.set_reg(CFG_SET_SHIFT, ss);
        @(negedge clk);
        cfg_index <= CFG_ACTIVE_WAYS;
        cfg_data  <= aw;
        sb.set_reg(CFG_ACTIVE_WAYS, aw);
        @(negedge clk);
        cfg_we <= 1'b0;
        cur_bs = bs[BS_W-1:0];
        cur_ss = ss;
    endtask

    function logic [DEF_ADDR_BITS-1:0] next_address();
        logic [63:0] a;
        logic [63:0] lowmask;
        int          pick;
        int          sh;
        sh = cur_bs + ((cur_ss > SETS_LOG2) ? SETS_LOG2 : int'(cur_ss));
        lowmask = (64'd1 << sh) - 64'd1;
        pick = $urandom_range(0, 9);
        if (recent_n == 0 || pick >= 7)
        begin
            a = 64'($urandom);
        end
        else
        begin
            a = 64'(recent_addr[$urandom_range(0, recent_n - 1)]);
            if (pick < 4)
                a = a ^ (64'($urandom) & ((64'd1 << cur_bs) - 64'd1));
            else
                a = (a & lowmask) | (64'($urandom_range(0, 15)) << sh);
        end
        recent_addr[recent_wr] = a[DEF_ADDR_BITS-1:0];
        recent_wr = (recent_wr + 1) % 16;
        if (recent_n < 16)
            recent_n++;
        return a[DEF_ADDR_BITS-1:0];
    endfunction

    task run_random_phase(int count);
        int sent;
        int burst;
        int k;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 24);
            for (k = 0; k < burst && sent < count; k++)
            begin
                send_lookup(next_address());
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 8));
        end
        drain_results();
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] phase_bs [8];
        logic [SS_W-1:0]       phase_ss [8];
        logic [AWAYS_W-1:0]    phase_aw [8];
        int                    p;
        int                    i;
        phase_bs = '{4'd0, 4'd7, 4'd11, 4'd2, 4'd6, 4'd9, 4'd5, 4'd4};
        phase_ss = '{4'd0, 4'd13, 4'd15, 4'd14, 4'd2, 4'd1, 4'd4, 4'd3};
        phase_aw = '{4'd8, 4'd8, 4'd15, 4'd0, 4'd4, 4'd9, 4'd2, 4'd8};
        sb = new();
        hold_pending = 1'b0;
        recent_n = 0;
        recent_wr = 0;
        cur_bs = RST_BLOCK_SHIFT;
        cur_ss = RST_SET_SHIFT;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_BLOCK_SHIFT;
        cfg_data = '0;
        lookup_ch.valid = 1'b0;
        lookup_ch.address = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_lookup(32'h0000_0000);
        send_lookup(32'hFFFF_FFFF);
        send_lookup(32'h0000_0000);
        send_lookup(32'h0000_003F);
        send_lookup(32'hFFFF_FFC0);
        drain_results();

        // duplicate tags: fill two ways, shrink to one way, refill, grow again
        write_cfg(4'd0, 4'd0, 4'd2);
        send_lookup(32'h0000_0001);
        send_lookup(32'h0000_0002);
        send_lookup(32'h0000_0003);
        drain_results();
        write_cfg(4'd0, 4'd0, 4'd1);
        send_lookup(32'h0000_0003);
        drain_results();
        write_cfg(4'd0, 4'd0, 4'd2);
        send_lookup(32'h0000_0003);
        send_lookup(32'h0000_0003);
        drain_results();

        // oversized set and way counts; overfill one set to force eviction
        write_cfg(4'd7, 4'd15, 4'd15);
        for (i = 1; i <= 9; i++)
            send_lookup(DEF_ADDR_BITS'(i) << 20);
        send_lookup(32'h0090_0000);
        send_lookup(32'h0010_0000);
        drain_results();

        write_cfg(4'd5, 4'd14, 4'd0);
        send_lookup(32'h1234_5678);
        send_lookup(32'h1234_5660);
        drain_results();

        for (p = 0; p < NUM_PHASES; p++)
        begin
            if (p < 8)
                write_cfg(phase_bs[p], phase_ss[p], phase_aw[p]);
            else
                write_cfg(CFG_DATA_W'($urandom_range(0, 15)), SS_W'($urandom_range(0, 15)),
                          AWAYS_W'($urandom_range(0, 15)));
            if (p == 1)
                hold_pending = 1'b1;
            run_random_phase(PHASE_ITEMS);
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

@@ set_assoc_lru_cache_lookup.f @@
rtl/core/salc_pkg.sv
rtl/core/salc_in_if.sv
rtl/core/salc_out_if.sv
rtl/core/salc_ram.sv
rtl/core/set_assoc_lru_cache_lookup.sv
dv/tb.sv
